@@ rtl/core/plv_pkg.sv @@
// plv_pkg: command codes, cell operation codes and payload types for the
// positional list engine; no dependencies
`timescale 1ns / 1ps

package plv_pkg;

  // command codes of an input transfer
  localparam logic [2:0] CMD_INSERT_FRONT = 3'd0;
  localparam logic [2:0] CMD_INSERT_BACK  = 3'd1;
  localparam logic [2:0] CMD_INSERT_AT    = 3'd2;
  localparam logic [2:0] CMD_REMOVE_FRONT = 3'd3;
  localparam logic [2:0] CMD_REMOVE_BACK  = 3'd4;
  localparam logic [2:0] CMD_REMOVE_AT    = 3'd5;
  localparam logic [2:0] CMD_SEARCH       = 3'd6;
  localparam logic [2:0] CMD_NEGATE_ALL   = 3'd7;

  // operations broadcast to every cell of the row
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_INSERT = 3'd1;
  localparam logic [2:0] CELL_REMOVE = 3'd2;
  localparam logic [2:0] CELL_NEGATE = 3'd3;
  localparam logic [2:0] CELL_SEARCH = 3'd4;
  localparam logic [2:0] CELL_SCAN   = 3'd5;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [4:0]         position;
  } plv_in_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] removed_value;
    logic [4:0]         found_position;
    logic [4:0]         entry_count;
  } plv_out_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
  } plv_cell_ctrl_t;

endpackage

@@ rtl/core/plv_cell.sv @@
// plv_cell: one list slot; holds an entry word and a scan lane stage that
// hands its contents toward the head each scan cycle; uses plv_pkg
`timescale 1ns / 1ps

module plv_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  plv_pkg::plv_cell_ctrl_t ctrl,
  input  logic [CW-1:0]          at,
  input  logic [CW-1:0]          count,
  input  logic [31:0]            prev_word,
  input  logic [31:0]            next_word,
  input  logic [31:0]            next_lane_word,
  input  logic                   next_lane_flag,
  output logic [31:0]            word,
  output logic [31:0]            lane_word,
  output logic                   lane_flag
);
  import plv_pkg::*;

  localparam logic [CW-1:0] ME = CW'(IDX);

  logic held;
  assign held = (ME < count);

  // entry word and lane word, no reset
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (ME == at) begin
          word <= ctrl.value;
        end else if (ME > at) begin
          word <= prev_word;
        end
      end
      CELL_REMOVE: begin
        lane_word <= word;
        if (ME >= at) begin
          word <= next_word;
        end
      end
      CELL_NEGATE: begin
        if (held) begin
          word <= -word;
        end
      end
      CELL_SEARCH: begin
        lane_word <= word;
      end
      CELL_SCAN: begin
        lane_word <= next_lane_word;
      end
      default: begin
      end
    endcase
  end

  // lane hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_flag <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_REMOVE: lane_flag <= (ME == at);
        CELL_SEARCH: lane_flag <= held && (word == ctrl.value);
        CELL_SCAN:   lane_flag <= next_lane_flag;
        default:     lane_flag <= lane_flag;
      endcase
    end
  end

endmodule

@@ rtl/core/positional_list_engine.sv @@
// positional_list_engine: ordered list of signed words kept in a row of
// plv_cell slots with a scan controller; uses plv_pkg and plv_cell
//
//   channel   ports                  transfer when
//   --------  ---------------------  -----------------------------
//   command   start, busy, request   start high and busy low
//   result    done, result           done high, one cycle, no stall
//
// inserts, negate and every failing command: result in the cycle after the
// transfer, busy stays low, so a command may follow in every cycle
// remove: removed word shifts down the cell lane to the head; busy while it
// shifts, result in the cycle after the last busy cycle
// search: busy until the first match reaches the head or the last entry is scanned
// reset (rst, synchronous) empties the list, entry words kept; no stall
`timescale 1ns / 1ps

module positional_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  plv_pkg::plv_in_t  request,
  output logic              done,
  output plv_pkg::plv_out_t result
);
  import plv_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = $clog2(CAPACITY);
  localparam int XW = ((CW > 5) ? CW : 5) + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic          state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [KW-1:0] k;
  logic [KW-1:0] limit;
  logic [KW-1:0] limit_sel;
  logic          is_remove;
  logic          rem_sel;
  logic          go_scan;
  logic          imm_ok;
  logic [CW-1:0] at_sel;
  logic          accept;
  logic          full;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [CW-1:0] scan_pos;
  logic          scan_end;

  plv_cell_ctrl_t ctrl;

  logic [31:0] word      [CAPACITY];
  logic [31:0] lane_word [CAPACITY];
  logic        lane_flag [CAPACITY];

  assign busy     = (state == ST_SCAN);
  assign accept   = start && !busy;
  assign full     = (count == CW'(CAPACITY));
  assign pos_x    = XW'(request.position);
  assign cnt_x    = XW'(count);
  assign scan_pos = CW'(k) + CW'(1);
  assign scan_end = lane_flag[0] || (k == limit);

  // command decode and cell operation select
  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = request.value;
    at_sel     = '0;
    count_next = count;
    imm_ok     = 1'b0;
    go_scan    = 1'b0;
    rem_sel    = 1'b0;
    limit_sel  = '0;
    if (state == ST_SCAN) begin
      ctrl.op = CELL_SCAN;
    end else if (accept) begin
      case (request.command)
        CMD_INSERT_FRONT, CMD_INSERT_BACK, CMD_INSERT_AT: begin
          if (request.command == CMD_INSERT_BACK) begin
            at_sel = count;
          end else if (request.command == CMD_INSERT_AT) begin
            at_sel = CW'(pos_x - XW'(1));
          end
          if (!full && (request.command != CMD_INSERT_AT ||
                        (pos_x != '0 && pos_x <= cnt_x + XW'(1)))) begin
            ctrl.op    = CELL_INSERT;
            count_next = count + CW'(1);
            imm_ok     = 1'b1;
          end
        end
        CMD_REMOVE_FRONT, CMD_REMOVE_BACK, CMD_REMOVE_AT: begin
          if (request.command == CMD_REMOVE_BACK) begin
            at_sel = count - CW'(1);
          end else if (request.command == CMD_REMOVE_AT) begin
            at_sel = CW'(pos_x - XW'(1));
          end
          limit_sel = KW'(at_sel);
          rem_sel   = 1'b1;
          if (count != '0 && (request.command != CMD_REMOVE_AT ||
                              (pos_x != '0 && pos_x <= cnt_x))) begin
            ctrl.op    = CELL_REMOVE;
            count_next = count - CW'(1);
            go_scan    = 1'b1;
          end
        end
        CMD_SEARCH: begin
          limit_sel = KW'(count - CW'(1));
          if (count != '0) begin
            ctrl.op = CELL_SEARCH;
            go_scan = 1'b1;
          end
        end
        CMD_NEGATE_ALL: begin
          ctrl.op = CELL_NEGATE;
          imm_ok  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] prev_w;
    logic [31:0] next_w;
    logic [31:0] next_lw;
    logic        next_lf;
    if (i == 0) begin : g_head
      assign prev_w = ctrl.value;
    end else begin : g_body
      assign prev_w = word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_w  = word[i];
      assign next_lw = '0;
      assign next_lf = 1'b0;
    end else begin : g_link
      assign next_w  = word[i+1];
      assign next_lw = lane_word[i+1];
      assign next_lf = lane_flag[i+1];
    end
    plv_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .at             (at_sel),
      .count          (count),
      .prev_word      (prev_w),
      .next_word      (next_w),
      .next_lane_word (next_lw),
      .next_lane_flag (next_lf),
      .word           (word[i]),
      .lane_word      (lane_word[i]),
      .lane_flag      (lane_flag[i])
    );
  end

  // control state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      k         <= '0;
      limit     <= '0;
      is_remove <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == ST_IDLE) begin
        if (accept) begin
          count <= count_next;
          if (go_scan) begin
            state     <= ST_SCAN;
            k         <= '0;
            limit     <= limit_sel;
            is_remove <= rem_sel;
          end else begin
            done <= 1'b1;
          end
        end
      end else begin
        if (scan_end) begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end else begin
          k <= k + KW'(1);
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (accept && !go_scan) begin
        result.ok             <= imm_ok;
        result.removed_value  <= '0;
        result.found_position <= '0;
        result.entry_count    <= 5'(count_next);
      end
    end else if (scan_end) begin
      result.ok             <= lane_flag[0];
      result.removed_value  <= (is_remove && lane_flag[0]) ? lane_word[0] : '0;
      result.found_position <= (!is_remove && lane_flag[0]) ? 5'(scan_pos) : 5'd0;
      result.entry_count    <= 5'(count);
    end
  end

`ifndef ASSERT_OFF
  // a scan never runs past its last slot
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (k <= limit))
    else $error("scan index beyond its limit");

  // a remove always finds its word by the end of the scan
  a_remove_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && is_remove && k == limit) |-> lane_flag[0])
    else $error("remove scan ended without its word");

  // the count never exceeds the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a transfer that starts a scan holds off the next command
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && go_scan) |=> (busy && !done))
    else $error("scan did not raise busy");
`endif

endmodule
